// File: hdl/binary_to_decimal_ascii_defines.svh
// Assertion macros for the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define B2DA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define B2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define B2DA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define B2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/b2da_pkg.sv
package b2da_pkg;

	localparam int unsigned VALUE_BITS_DEF = 31;
	localparam int unsigned DIG_BITS       = 4;
	localparam int unsigned BITS_PER_STEP  = 4;
	localparam int unsigned FIFO_DEPTH     = 2;
	localparam int unsigned CHAR_BITS      = 6;
	localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

// File: hdl/b2da_in_if.sv
interface b2da_in_if import b2da_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

// File: hdl/b2da_out_if.sv
interface b2da_out_if import b2da_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CHAR_BITS-1:0] digit_char;
	logic                 is_last;

	modport source(output valid, output digit_char, output is_last, input ready);
	modport sink(input valid, input digit_char, input is_last, output ready);
endinterface

// File: hdl/b2da_front.sv
module b2da_front import b2da_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
	parameter int unsigned NDIG       = ((VALUE_BITS * 1233) >> 12) + 1,
	parameter int unsigned CW         = $clog2(NDIG),
	parameter int unsigned ENTRY_W    = NDIG * DIG_BITS + CW
) (
	input  logic               clk,
	input  logic               arst_n,
	b2da_in_if.sink            in_ch,
	output logic               push,
	output logic [ENTRY_W-1:0] push_data,
	input  fifo_status_t       status
);

	localparam int unsigned STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int unsigned PADW  = STEPS * BITS_PER_STEP;
	localparam int unsigned SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int unsigned BCDW  = NDIG * DIG_BITS;
	localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

	front_state_t    state_q, state_d;
	logic [BCDW-1:0] bcd_q, bcd_n;
	logic [PADW-1:0] bin_q, bin_n;
	logic [SW-1:0]   step_q;
	logic [CW-1:0]   cnt_m1;

	// double dabble, several bits per cycle
	always_comb begin
		bcd_n = bcd_q;
		bin_n = bin_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_n[d*DIG_BITS +: DIG_BITS] >= 4'd5) begin
					bcd_n[d*DIG_BITS +: DIG_BITS] = bcd_n[d*DIG_BITS +: DIG_BITS] + 4'd3;
				end
			end
			bcd_n = {bcd_n[BCDW-2:0], bin_n[PADW-1]};
			bin_n = {bin_n[PADW-2:0], 1'b0};
		end
	end

	// highest nonzero digit
	always_comb begin
		cnt_m1 = '0;
		for (int d = 1; d < NDIG; d++) begin
			if (bcd_q[d*DIG_BITS +: DIG_BITS] != '0) begin
				cnt_m1 = CW'(d);
			end
		end
	end

	assign push_data = {cnt_m1, bcd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		push        = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = F_CONV;
				end
			end
			F_CONV: begin
				if (step_q == '0) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!status.full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			bin_q  <= PADW'(in_ch.value);
			bcd_q  <= '0;
			step_q <= LAST_STEP;
		end else if (state_q == F_CONV) begin
			bin_q  <= bin_n;
			bcd_q  <= bcd_n;
			step_q <= step_q - 1'b1;
		end
	end

endmodule

// File: hdl/b2da_fifo.sv
module b2da_fifo import b2da_pkg::*; #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output fifo_status_t     status
);

	localparam int unsigned PW = $clog2(FIFO_DEPTH);
	localparam int unsigned NW = $clog2(FIFO_DEPTH + 1);
	localparam logic [NW-1:0] FULL_CNT = NW'(FIFO_DEPTH);

	logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [NW-1:0]    cnt_q;

	assign status.full  = (cnt_q == FULL_CNT);
	assign status.empty = (cnt_q == '0);
	assign pop_data     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// File: hdl/b2da_back.sv
module b2da_back import b2da_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
	parameter int unsigned NDIG       = ((VALUE_BITS * 1233) >> 12) + 1,
	parameter int unsigned CW         = $clog2(NDIG),
	parameter int unsigned ENTRY_W    = NDIG * DIG_BITS + CW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fifo_status_t       status,
	input  logic [ENTRY_W-1:0] head,
	output logic               pop,
	b2da_out_if.source         out_ch
);

	localparam int unsigned BCDW = NDIG * DIG_BITS;

	logic                 started_q;
	logic [CW-1:0]        idx_q;
	logic                 out_valid_q;
	logic [CHAR_BITS-1:0] digit_q;
	logic                 last_q;

	logic [CW-1:0]       head_cnt;
	logic [BCDW-1:0]     head_bcd;
	logic [CW-1:0]       pos;
	logic [DIG_BITS-1:0] digit;
	logic                load;

	assign head_cnt = head[ENTRY_W-1 -: CW];
	assign head_bcd = head[BCDW-1:0];
	assign pos      = started_q ? idx_q : head_cnt;
	assign digit    = head_bcd[pos*DIG_BITS +: DIG_BITS];
	assign load     = !status.empty && (!out_valid_q || out_ch.ready);
	assign pop      = load && (pos == '0);

	assign out_ch.valid      = out_valid_q;
	assign out_ch.digit_char = digit_q;
	assign out_ch.is_last    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				started_q   <= (pos != '0);
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digit_q <= ASCII_ZERO + {{(CHAR_BITS-DIG_BITS){1'b0}}, digit};
			last_q  <= (pos == '0);
			idx_q   <= pos - 1'b1;
		end
	end

endmodule

// File: hdl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter. Each input item is an unsigned integer of
// VALUE_BITS bits; the block answers with its decimal digits as ASCII codes, most
// significant first, one output item per digit, leading zeros dropped (zero gives
// a single '0'), is_last set on the final digit. The front end converts with a
// double-dabble unit that takes four bits per cycle; it accepts a new value only
// once the last one has been pushed into a two-entry queue of BCD words, and it
// waits while that queue is full. The queue feeds the back end, which emits one
// digit per cycle while the output is ready and the queue is not empty.
`include "binary_to_decimal_ascii_defines.svh"
module binary_to_decimal_ascii import b2da_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	b2da_in_if.sink    in_ch,
	b2da_out_if.source out_ch
);

	localparam int unsigned NDIG    = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int unsigned CW      = $clog2(NDIG);
	localparam int unsigned ENTRY_W = NDIG * DIG_BITS + CW;

	logic               push;
	logic [ENTRY_W-1:0] push_data;
	logic               pop;
	logic [ENTRY_W-1:0] head;
	fifo_status_t       status;

	b2da_front #(
		.VALUE_BITS(VALUE_BITS),
		.NDIG      (NDIG),
		.CW        (CW),
		.ENTRY_W   (ENTRY_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.push     (push),
		.push_data(push_data),
		.status   (status)
	);

	b2da_fifo #(
		.WIDTH(ENTRY_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (head),
		.status   (status)
	);

	b2da_back #(
		.VALUE_BITS(VALUE_BITS),
		.NDIG      (NDIG),
		.CW        (CW),
		.ENTRY_W   (ENTRY_W)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.head  (head),
		.pop   (pop),
		.out_ch(out_ch)
	);

	`B2DA_ASSERT_IMPL(a_push_not_full, clk, arst_n, push, !status.full)
	`B2DA_ASSERT_IMPL(a_pop_not_empty, clk, arst_n, pop, !status.empty)
	`B2DA_ASSERT_IMPL(a_fifo_status, clk, arst_n, 1'b1, !(status.full && status.empty))
	`B2DA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule
